FILE: rtl/core/pmr_pkg.sv
package pmr_pkg;

    // gene format
    localparam int VALUE_WIDTH = 32;
    localparam int RANGE_W     = VALUE_WIDTH + 1;   // upper - lower
    localparam int REM_W       = RANGE_W + 1;       // divider partial remainder
    localparam int PERIOD_W    = VALUE_WIDTH + 2;   // 2 * range
    localparam int OFS_W       = VALUE_WIDTH + 3;   // signed offset from lower
    localparam int MAG_W       = OFS_W;             // magnitude of that offset

    // 0.16 fixed point, one = 65536
    localparam int DRAW_W = 16;
    localparam int FRAC_W = 17;
    localparam logic [FRAC_W-1:0] ONE  = 17'h10000;
    localparam logic [DRAW_W-1:0] HALF = 16'h8000;

    localparam int TAG_W = 3 * FRAC_W;

    // back pipeline stage map
    localparam int QBITS      = FRAC_W;
    localparam int POW_LAT    = 6;
    localparam int ROOT_STEPS = FRAC_W;
    localparam int ITER_LAT   = POW_LAT + 1;
    localparam int DIV_LAST   = QBITS - 1;
    localparam int POW_LAST   = DIV_LAST + POW_LAT;
    localparam int VAL_STG    = POW_LAST + 1;
    localparam int ROOT_LAST  = VAL_STG + ROOT_STEPS * ITER_LAT;
    localparam int SCALE_STG  = ROOT_LAST + 1;
    localparam int OFS_STG    = SCALE_STG + 1;
    localparam int MOD_FIRST  = OFS_STG + 1;
    localparam int MOD_LAST   = OFS_STG + MAG_W;
    localparam int SEL_STG    = MOD_LAST + 1;
    localparam int DEPTH      = SEL_STG + 1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] gene;
        logic signed [VALUE_WIDTH-1:0] x;
        logic signed [VALUE_WIDTH-1:0] lower;
        logic [RANGE_W-1:0]            range;
        logic [DRAW_W-1:0]             u;
        logic                          left;
        logic                          mut;
        logic                          err;
        logic                          last;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [RANGE_W-1:0] offset;
    } item_t;

    function automatic logic [FRAC_W-1:0] qmul(input logic [FRAC_W-1:0] a,
                                               input logic [FRAC_W-1:0] b);
        logic [2*FRAC_W:0] prod;
        prod = (2*FRAC_W+1)'(a) * (2*FRAC_W+1)'(b) + (2*FRAC_W+1)'(HALF);
        return prod[FRAC_W+15:16];
    endfunction

endpackage

FILE: rtl/core/pmr_front.sv
module pmr_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [pmr_pkg::DRAW_W-1:0]         cfg_data,
    input  logic signed [pmr_pkg::VALUE_WIDTH-1:0] gene_value,
    input  logic signed [pmr_pkg::VALUE_WIDTH-1:0] lower_bound,
    input  logic signed [pmr_pkg::VALUE_WIDTH-1:0] upper_bound,
    input  logic [pmr_pkg::DRAW_W-1:0]         mutate_draw,
    input  logic [pmr_pkg::DRAW_W-1:0]         shape_draw,
    input  logic                               gene_last,
    output pmr_pkg::item_t                     item
);

    logic [pmr_pkg::DRAW_W-1:0] rate_reg;
    logic [pmr_pkg::DRAW_W-1:0] rate_next;
    logic signed [pmr_pkg::VALUE_WIDTH-1:0] x;
    logic [pmr_pkg::RANGE_W-1:0] lo_ext;
    logic [pmr_pkg::RANGE_W-1:0] up_ext;
    logic [pmr_pkg::RANGE_W-1:0] x_ext;
    logic err;
    logic left;

    always_comb
    begin
        rate_next = cfg_valid ? cfg_data : rate_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= '0;
        end
        else
        begin
            rate_reg <= rate_next;
        end
    end

    always_comb
    begin
        err  = !(upper_bound > lower_bound);
        left = (shape_draw <= pmr_pkg::HALF);
        if (gene_value < lower_bound)
        begin
            x = lower_bound;
        end
        else if (gene_value > upper_bound)
        begin
            x = upper_bound;
        end
        else
        begin
            x = gene_value;
        end
        lo_ext = {lower_bound[pmr_pkg::VALUE_WIDTH-1], lower_bound};
        up_ext = {upper_bound[pmr_pkg::VALUE_WIDTH-1], upper_bound};
        x_ext  = {x[pmr_pkg::VALUE_WIDTH-1], x};

        item.side.gene  = gene_value;
        item.side.x     = x;
        item.side.lower = lower_bound;
        item.side.range = up_ext - lo_ext;
        item.side.u     = shape_draw;
        item.side.left  = left;
        item.side.mut   = !err && (mutate_draw < rate_reg);
        item.side.err   = err;
        item.side.last  = gene_last;
        item.offset     = left ? (x_ext - lo_ext) : (up_ext - x_ext);
    end

endmodule

FILE: rtl/core/pmr_queue.sv
module pmr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pmr_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output pmr_pkg::item_t head_item,
    output logic           empty
);

    pmr_pkg::item_t mem_reg [pmr_pkg::QUEUE_DEPTH];
    logic wr_ptr_reg;
    logic wr_ptr_next;
    logic rd_ptr_reg;
    logic rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        full        = (count_reg == 2'(pmr_pkg::QUEUE_DEPTH));
        empty       = (count_reg == 2'd0);
        head_item   = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/pmr_pow21.sv
module pmr_pow21 (
    input  logic                        clk,
    input  logic                        en,
    input  logic [pmr_pkg::FRAC_W-1:0]  x,
    input  logic [pmr_pkg::TAG_W-1:0]   tag_in,
    output logic [pmr_pkg::FRAC_W-1:0]  p,
    output logic [pmr_pkg::TAG_W-1:0]   tag_out
);

    // x2, x4, x5, x10, x20, x21: one product per stage
    logic [pmr_pkg::FRAC_W-1:0] x_reg   [pmr_pkg::POW_LAT-1];
    logic [pmr_pkg::FRAC_W-1:0] acc_reg [pmr_pkg::POW_LAT];
    logic [pmr_pkg::TAG_W-1:0]  tag_reg [pmr_pkg::POW_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x;
            acc_reg[0] <= pmr_pkg::qmul(x, x);
            x_reg[1]   <= x_reg[0];
            acc_reg[1] <= pmr_pkg::qmul(acc_reg[0], acc_reg[0]);
            x_reg[2]   <= x_reg[1];
            acc_reg[2] <= pmr_pkg::qmul(acc_reg[1], x_reg[1]);
            x_reg[3]   <= x_reg[2];
            acc_reg[3] <= pmr_pkg::qmul(acc_reg[2], acc_reg[2]);
            x_reg[4]   <= x_reg[3];
            acc_reg[4] <= pmr_pkg::qmul(acc_reg[3], acc_reg[3]);
            acc_reg[5] <= pmr_pkg::qmul(acc_reg[4], x_reg[4]);
            tag_reg[0] <= tag_in;
            for (int i = 1; i < pmr_pkg::POW_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign p       = acc_reg[pmr_pkg::POW_LAT-1];
    assign tag_out = tag_reg[pmr_pkg::POW_LAT-1];

endmodule

FILE: rtl/core/pmr_back.sv
module pmr_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  pmr_pkg::item_t                      in_item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pmr_pkg::VALUE_WIDTH-1:0]     out_value,
    output logic                                out_mutated,
    output logic                                out_error,
    output logic                                out_last
);

    localparam int VW = pmr_pkg::VALUE_WIDTH;
    localparam int FW = pmr_pkg::FRAC_W;
    localparam int RW = pmr_pkg::RANGE_W;
    localparam int EW = pmr_pkg::REM_W;
    localparam int PW = pmr_pkg::PERIOD_W;
    localparam int OW = pmr_pkg::OFS_W;
    localparam int MW = pmr_pkg::MAG_W;

    logic en;
    logic vld_reg [pmr_pkg::DEPTH];
    pmr_pkg::side_t side_reg [pmr_pkg::DEPTH];

    logic out_valid_reg;
    logic out_valid_next;
    logic [VW-1:0] out_value_reg;
    logic out_mutated_reg;
    logic out_error_reg;
    logic out_last_reg;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pmr_pkg::DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < pmr_pkg::DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_item.side;
            for (int i = 1; i < pmr_pkg::DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // restoring divider, one quotient bit per stage: floor(offset * 2^16 / range)
    logic [EW-1:0] drem_reg [pmr_pkg::QBITS];
    logic [FW-1:0] dq_reg   [pmr_pkg::QBITS];

    for (genvar k = 0; k < pmr_pkg::QBITS; k++)
    begin : g_div
        logic [EW-1:0] r_in;
        logic [EW-1:0] rng;
        logic          qbit;
        logic [FW-1:0] q_prev;
        if (k == 0)
        begin : g_first
            always_comb
            begin
                r_in   = {1'b0, in_item.offset};
                rng    = {1'b0, in_item.side.range};
                q_prev = '0;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                r_in   = {drem_reg[k-1][EW-2:0], 1'b0};
                rng    = {1'b0, side_reg[k-1].range};
                q_prev = dq_reg[k-1];
            end
        end
        assign qbit = (r_in >= rng);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[k] <= qbit ? (r_in - rng) : r_in;
                dq_reg[k]   <= {q_prev[FW-2:0], qbit};
            end
        end
    end

    // xy^21
    logic [FW-1:0] xy;
    logic [FW-1:0] p_xy;
    logic [pmr_pkg::TAG_W-1:0] tag_unused;

    assign xy = pmr_pkg::ONE - dq_reg[pmr_pkg::DIV_LAST];

    pmr_pow21 u_pow_xy (
        .clk     (clk),
        .en      (en),
        .x       (xy),
        .tag_in  ('0),
        .p       (p_xy),
        .tag_out (tag_unused)
    );

    // target value for the root
    logic [FW-1:0] val_reg;
    logic [FW-1:0] two_u;
    logic [FW:0]   val_sum;
    logic [FW-1:0] val_sat;

    always_comb
    begin
        two_u = {side_reg[pmr_pkg::POW_LAST].u, 1'b0};
        if (side_reg[pmr_pkg::POW_LAST].left)
        begin
            val_sum = (FW+1)'(two_u)
                    + (FW+1)'(pmr_pkg::qmul(pmr_pkg::ONE - two_u, p_xy));
        end
        else
        begin
            val_sum = {pmr_pkg::ONE, 1'b0} - (FW+1)'(two_u)
                    + (FW+1)'(pmr_pkg::qmul(two_u - pmr_pkg::ONE, p_xy));
        end
        val_sat = (val_sum > (FW+1)'(pmr_pkg::ONE)) ? pmr_pkg::ONE : val_sum[FW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_sat;
        end
    end

    // 21st root by bisection, one step per pow21 pass
    logic [FW-1:0] lo_reg [pmr_pkg::ROOT_STEPS];
    logic [FW-1:0] hi_reg [pmr_pkg::ROOT_STEPS];
    logic [FW-1:0] tv_reg [pmr_pkg::ROOT_STEPS];

    for (genvar j = 0; j < pmr_pkg::ROOT_STEPS; j++)
    begin : g_root
        logic [FW-1:0] lo_in;
        logic [FW-1:0] hi_in;
        logic [FW-1:0] tv_in;
        logic [FW:0]   mid_sum;
        logic [FW-1:0] mid;
        logic [FW-1:0] p_mid;
        logic [pmr_pkg::TAG_W-1:0] tag_o;
        logic [FW-1:0] lo_o;
        logic [FW-1:0] hi_o;
        logic [FW-1:0] tv_o;
        logic [FW:0]   mid_o_sum;
        logic [FW-1:0] mid_o;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                lo_in = '0;
                hi_in = pmr_pkg::ONE;
                tv_in = val_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                lo_in = lo_reg[j-1];
                hi_in = hi_reg[j-1];
                tv_in = tv_reg[j-1];
            end
        end

        assign mid_sum = (FW+1)'(lo_in) + (FW+1)'(hi_in);
        assign mid     = mid_sum[FW:1];

        pmr_pow21 u_pow (
            .clk     (clk),
            .en      (en),
            .x       (mid),
            .tag_in  ({lo_in, hi_in, tv_in}),
            .p       (p_mid),
            .tag_out (tag_o)
        );

        assign lo_o      = tag_o[3*FW-1:2*FW];
        assign hi_o      = tag_o[2*FW-1:FW];
        assign tv_o      = tag_o[FW-1:0];
        assign mid_o_sum = (FW+1)'(lo_o) + (FW+1)'(hi_o);
        assign mid_o     = mid_o_sum[FW:1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tv_reg[j] <= tv_o;
                if ((lo_o < hi_o) && (p_mid >= tv_o))
                begin
                    lo_reg[j] <= lo_o;
                    hi_reg[j] <= mid_o;
                end
                else if (lo_o < hi_o)
                begin
                    lo_reg[j] <= mid_o + FW'(1);
                    hi_reg[j] <= hi_o;
                end
                else
                begin
                    lo_reg[j] <= lo_o;
                    hi_reg[j] <= hi_o;
                end
            end
        end
    end

    // shift size: floor(range * (1 - root) / 2^16)
    logic [RW-1:0] mag_reg;
    logic [FW-1:0] dq_mag;
    logic [2*FW-1:0] prod_hi;
    logic [2*FW-1:0] prod_lo;
    logic [2*FW-1:0] mag_sum;
    pmr_pkg::side_t s_scale;

    always_comb
    begin
        s_scale = side_reg[pmr_pkg::ROOT_LAST];
        dq_mag  = pmr_pkg::ONE - lo_reg[pmr_pkg::ROOT_STEPS-1];
        prod_hi = (2*FW)'(s_scale.range[RW-1:16]) * (2*FW)'(dq_mag);
        prod_lo = (2*FW)'(s_scale.range[15:0]) * (2*FW)'(dq_mag);
        mag_sum = prod_hi + (2*FW)'(prod_lo[2*FW-1:16]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_sum[RW-1:0];
        end
    end

    // offset of the new value from lower
    logic [OW-1:0] t_reg;
    logic [OW-1:0] base_ext;
    logic [OW-1:0] low_ext_o;
    logic [OW-1:0] d0;
    pmr_pkg::side_t s_ofs;

    always_comb
    begin
        s_ofs     = side_reg[pmr_pkg::SCALE_STG];
        base_ext  = s_ofs.mut ? OW'(signed'(s_ofs.x)) : OW'(signed'(s_ofs.gene));
        low_ext_o = OW'(signed'(s_ofs.lower));
        d0        = base_ext - low_ext_o;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!s_ofs.mut)
            begin
                t_reg <= d0;
            end
            else if (s_ofs.left)
            begin
                t_reg <= d0 - OW'(mag_reg);
            end
            else
            begin
                t_reg <= d0 + OW'(mag_reg);
            end
        end
    end

    // |t| mod period, one dividend bit per stage
    logic [PW-1:0] mrem_reg  [MW];
    logic [MW-1:0] mbits_reg [MW];
    logic          mneg_reg  [MW];

    for (genvar m = 0; m < MW; m++)
    begin : g_mod
        logic [PW-1:0] rem_prev;
        logic [MW-1:0] bits_prev;
        logic          neg_prev;
        logic [PW:0]   r_in;
        logic [PW:0]   per;
        if (m == 0)
        begin : g_first
            always_comb
            begin
                rem_prev  = '0;
                neg_prev  = t_reg[OW-1];
                bits_prev = t_reg[OW-1] ? (MW'(0) - t_reg) : t_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                rem_prev  = mrem_reg[m-1];
                neg_prev  = mneg_reg[m-1];
                bits_prev = mbits_reg[m-1];
            end
        end
        assign r_in = {rem_prev, bits_prev[MW-1]};
        assign per  = {1'b0, side_reg[pmr_pkg::MOD_FIRST+m-1].range, 1'b0};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mrem_reg[m]  <= (r_in >= per) ? PW'(r_in - per) : PW'(r_in);
                mbits_reg[m] <= {bits_prev[MW-2:0], 1'b0};
                mneg_reg[m]  <= neg_prev;
            end
        end
    end

    // fold into [0, period)
    logic [PW-1:0] s_reg;
    logic [PW-1:0] per_sel;
    logic [PW-1:0] r_fin;

    always_comb
    begin
        per_sel = {side_reg[pmr_pkg::MOD_LAST].range, 1'b0};
        r_fin   = mrem_reg[MW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= (mneg_reg[MW-1] && (r_fin != '0)) ? (per_sel - r_fin) : r_fin;
        end
    end

    // reflect and register the result
    pmr_pkg::side_t s_out;
    logic [OW-1:0] low_ext;
    logic [OW-1:0] refl;
    logic [VW-1:0] value_sel;

    always_comb
    begin
        s_out   = side_reg[pmr_pkg::SEL_STG];
        low_ext = OW'(signed'(s_out.lower));
        if (s_reg <= PW'(s_out.range))
        begin
            refl = low_ext + OW'(s_reg);
        end
        else
        begin
            refl = low_ext + OW'({s_out.range, 1'b0}) - OW'(s_reg);
        end
        value_sel      = s_out.err ? s_out.gene : refl[VW-1:0];
        out_valid_next = en ? vld_reg[pmr_pkg::SEL_STG] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg   <= value_sel;
            out_mutated_reg <= s_out.mut;
            out_error_reg   <= s_out.err;
            out_last_reg    <= s_out.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_mutated = out_mutated_reg;
    assign out_error   = out_error_reg;
    assign out_last    = out_last_reg;

endmodule

FILE: rtl/core/polynomial_mutation_reflect_core.sv
// polynomial mutation and bound reflection for one gene per beat. a gene
// (signed q16.16) mutates when its draw is below the rate register and
// upper > lower: it is clamped, moved by deb polynomial mutation (index 20)
// and folded back into [lower, upper]; bad bounds pass the gene unchanged
// with the error flag set. a new beat is taken every cycle while the result
// side keeps up. the pipe holds 17 divider stages, 17 bisection steps of
// the 21st root, each a six-stage power pipeline plus an update, and 35
// stages of the remainder that folds the value into its bounds.
module polynomial_mutation_reflect_core (
    input  logic         clk,
    input  logic         rst_n,

    // rate register write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,

    // gene in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // gene_value, lower_bound, upper_bound, mutate_draw, shape_draw
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tlast,

    // gene out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_value
    output logic [31:0]  m_axis_tdata,
    // was_mutated, bounds_error
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    pmr_pkg::item_t front_item;
    pmr_pkg::item_t head_item;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic push;

    // rate register is always writable
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    // classify: bounds check, mutate decision, clamp and distance
    pmr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .gene_value  (s_axis_tdata[31:0]),
        .lower_bound (s_axis_tdata[63:32]),
        .upper_bound (s_axis_tdata[95:64]),
        .mutate_draw (s_axis_tdata[111:96]),
        .shape_draw  (s_axis_tdata[127:112]),
        .gene_last   (s_axis_tlast),
        .item        (front_item)
    );

    // short queue so intake and the arithmetic pipe stall independently
    pmr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    // mutation, root search and reflection pipeline
    pmr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!q_empty),
        .in_item     (head_item),
        .pop         (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (m_axis_tdata),
        .out_mutated (m_axis_tuser[0]),
        .out_error   (m_axis_tuser[1]),
        .out_last    (m_axis_tlast)
    );

endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // gene_value, lower_bound, upper_bound, mutate_draw, shape_draw
    logic [127:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // new_value
    logic [31:0]  m_axis_tdata;
    // was_mutated, bounds_error
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    typedef struct packed {
        logic signed [31:0] value;
        logic               mutated;
        logic               bad_bounds;
        logic               last;
    } gene_result_t;

    polynomial_mutation_reflect_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // pending genes (tdata plus tlast) and the results they must produce
    logic [128:0]   gene_queue[$];
    gene_result_t   expected_genes[$];
    logic [15:0]    rate_model;
    int             error_count;
    int             gene_count;
    int             mutated_count;
    int             bad_bounds_count;
    int             reflected_count;
    int             idle_cycles;
    bit             hold_off;
    int             burst_left;
    int             gap_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // fixed point multiply with rounding, 0.16 format
    function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] frac_pow21(logic [63:0] x);
        logic [63:0] sq;
        logic [63:0] p4;
        logic [63:0] p5;
        logic [63:0] p10;
        logic [63:0] p20;
        sq  = frac_mul(x, x);
        p4  = frac_mul(sq, sq);
        p5  = frac_mul(p4, x);
        p10 = frac_mul(p5, p5);
        p20 = frac_mul(p10, p10);
        return frac_mul(p20, x);
    endfunction

    // smallest r in [0, 1.0] with r^21 >= target
    function automatic logic [63:0] frac_root21(logic [63:0] target);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'd65536;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (frac_pow21(mid) >= target)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic gene_result_t mutate_and_reflect(logic [31:0] gene_bits,
                                                        logic [31:0] lower_bits,
                                                        logic [31:0] upper_bits,
                                                        logic [15:0] mdraw,
                                                        logic [15:0] u,
                                                        logic        last);
        gene_result_t res;
        longint gene;
        longint lower;
        longint upper;
        longint span;
        longint period;
        longint x;
        longint v;
        longint s;
        logic [63:0] d1;
        logic [63:0] d2;
        logic [63:0] xy;
        logic [63:0] p;
        logic [63:0] val;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] mag;
        logic [63:0] u2;
        bit left;
        gene  = longint'(signed'(gene_bits));
        lower = longint'(signed'(lower_bits));
        upper = longint'(signed'(upper_bits));
        res.last = last;
        res.mutated = 1'b0;
        if (upper <= lower)
        begin
            res.value = gene_bits;
            res.bad_bounds = 1'b1;
            return res;
        end
        res.bad_bounds = 1'b0;
        span   = upper - lower;
        period = 2 * span;
        v      = gene;
        if (mdraw < rate_model)
        begin
            x  = gene < lower ? lower : (gene > upper ? upper : gene);
            d1 = (64'(x - lower) << 16) / 64'(span);
            d2 = (64'(upper - x) << 16) / 64'(span);
            if (d1 > 64'd65536) d1 = 64'd65536;
            if (d2 > 64'd65536) d2 = 64'd65536;
            left = (u <= 16'h8000);
            u2 = 64'(u) * 2;
            xy = left ? 64'd65536 - d1 : 64'd65536 - d2;
            p  = frac_pow21(xy);
            if (left)
                val = u2 + frac_mul(64'd65536 - u2, p);
            else
                val = (64'd131072 - u2) + frac_mul(u2 - 64'd65536, p);
            if (val > 64'd65536) val = 64'd65536;
            r   = frac_root21(val);
            q   = 64'd65536 - r;
            mag = (64'(span) >> 16) * q + (((64'(span) & 64'hFFFF) * q) >> 16);
            v   = left ? x - longint'(mag) : x + longint'(mag);
            res.mutated = 1'b1;
        end
        s = (v - lower) % period;
        if (s < 0)
            s += period;
        if (s <= span)
            v = lower + s;
        else
            v = upper - (s - span);
        res.value = v[31:0];
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        return $urandom();
    endfunction

    task automatic add_gene(logic [31:0] g, logic [31:0] lo, logic [31:0] hi,
                            logic [15:0] md, logic [15:0] u, logic last);
        gene_queue.insert(gene_queue.size(), {last, u, md, hi, lo, g});
    endtask

    // mostly well-formed bounds with random span width, gene near, inside or outside them
    task automatic add_random_gene();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] g;
        longint lo_i;
        longint span;
        longint gi;
        int sh;
        int kind;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            add_gene(rand_word(), rand_word(), rand_word(), 16'($urandom()),
                     16'($urandom()), 1'($urandom_range(0, 1)));
            return;
        end
        sh   = $urandom_range(0, 31);
        span = longint'($urandom() >> (31 - sh)) + 1;
        lo_i = longint'(signed'(rand_word()));
        if (lo_i + span > 64'sd2147483647)
            lo_i = 64'sd2147483647 - span;
        if (kind == 1)
            span = -longint'($urandom_range(0, 3));
        lo = lo_i[31:0];
        hi = 32'(lo_i + span);
        case ($urandom_range(0, 3))
            0: gi = lo_i + longint'($urandom_range(0, 3));
            1: gi = lo_i + span - longint'($urandom_range(0, 3));
            2: gi = longint'(signed'(rand_word()));
            default: gi = lo_i + (span > 0 ? longint'($urandom()) % (span + 1) : 0);
        endcase
        if (gi > 64'sd2147483647) gi = 64'sd2147483647;
        if (gi < -64'sd2147483648) gi = -64'sd2147483648;
        g = gi[31:0];
        add_gene(g, lo, hi, 16'($urandom()), 16'($urandom()),
                 1'($urandom_range(0, 1)));
    endtask

    task automatic write_rate(logic [15:0] rate);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_model = rate;
    endtask

    // wait for the pipe to drain, then idle on to catch any late beats
    task automatic drain();
        while (gene_queue.size() != 0 || expected_genes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // driver: bursts of beats separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            automatic bit taken = s_axis_tvalid && s_axis_tready;
            automatic bit busy  = s_axis_tvalid && !s_axis_tready;
            if (taken)
            begin
                expected_genes.insert(expected_genes.size(),
                    mutate_and_reflect(s_axis_tdata[31:0],
                    s_axis_tdata[63:32], s_axis_tdata[95:64], s_axis_tdata[111:96],
                    s_axis_tdata[127:112], s_axis_tlast));
                gene_count++;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (gene_queue.size() != 0)
                begin
                    automatic logic [128:0] beat = gene_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= beat[127:0];
                    s_axis_tlast  <= beat[128];
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor with its own stall pattern and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            idle_cycles   <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_genes.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    automatic gene_result_t want = expected_genes.pop_front();
                    if (m_axis_tdata !== want.value)
                    begin
                        $error("new_value expected %h got %h", want.value, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser[0] !== want.mutated)
                    begin
                        $error("was_mutated expected %b got %b", want.mutated,
                               m_axis_tuser[0]);
                        error_count++;
                    end
                    if (m_axis_tuser[1] !== want.bad_bounds)
                    begin
                        $error("bounds_error expected %b got %b", want.bad_bounds,
                               m_axis_tuser[1]);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("result_last expected %b got %b", want.last, m_axis_tlast);
                        error_count++;
                    end
                    mutated_count    += want.mutated;
                    bad_bounds_count += want.bad_bounds;
                    if (want.value != m_axis_tdata || !want.mutated)
                        reflected_count++;
                end
            end
            if (hold_off)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= (gene_count % 300 < 120) ? 1'b1 : ($urandom_range(0, 3) != 0);
            // watchdog: cycles in which nothing moves on either side
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (gene_queue.size() == 0 && expected_genes.size() == 0))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("polynomial_mutation_reflect_core test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [15:0] rates[5];
        rates = '{16'hFFFF, 16'h8000, 16'h0001, 16'h0000, 16'hC000};
        error_count = 0;
        gene_count = 0;
        mutated_count = 0;
        bad_bounds_count = 0;
        reflected_count = 0;
        hold_off = 1'b0;
        rate_model = 16'h0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset rate: nothing mutates, only reflection
        add_gene(32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 16'h0000, 16'h0, 1'b0);
        add_gene(32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000, 16'h0000, 16'h0, 1'b0);
        add_gene(32'h8000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        add_gene(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0, 1'b0);
        drain();

        write_rate(16'hFFFF);
        // both sides, u extremes, half point, clamped genes, bad bounds
        add_gene(32'h0000_8000, 32'h0000_0000, 32'h0001_0000, 16'h0000, 16'h0000, 1'b0);
        add_gene(32'h0000_8000, 32'h0000_0000, 32'h0001_0000, 16'h0000, 16'hFFFF, 1'b0);
        add_gene(32'h0000_8000, 32'h0000_0000, 32'h0001_0000, 16'h0000, 16'h8000, 1'b0);
        add_gene(32'h0000_8000, 32'h0000_0000, 32'h0001_0000, 16'h0000, 16'h8001, 1'b0);
        add_gene(32'h8000_0000, 32'hFFF0_0000, 32'h0010_0000, 16'h1234, 16'h4000, 1'b0);
        add_gene(32'h7FFF_FFFF, 32'hFFF0_0000, 32'h0010_0000, 16'h1234, 16'hC000, 1'b0);
        add_gene(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFE, 16'h0001, 1'b1);
        add_gene(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'hFFFE, 1'b0);
        add_gene(32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 16'h0, 16'h0, 1'b0);
        add_gene(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 16'h0, 1'b1);
        add_gene(32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 16'h0, 16'h7000, 1'b0);
        add_gene(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 16'hFFFF, 16'hF000, 1'b0);
        drain();

        // random phases over several rates, one long receiver hold-off
        foreach (rates[i])
        begin
            write_rate(rates[i]);
            repeat (260) add_random_gene();
            if (i == 1)
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            drain();
        end

        $display("covered %0d genes: %0d mutated, %0d with bad bounds, rates 0 to ffff",
                 gene_count, mutated_count, bad_bounds_count);
        if (error_count == 0)
            $display("polynomial_mutation_reflect_core test passed");
        else
            $display("polynomial_mutation_reflect_core test failed");
        $finish;
    end
endmodule
